### hdl/m2mp_pkg.sv
// shared types and constants for the 2x2 modular matrix power block
// no dependencies
package m2mp_pkg;

    localparam int ELEM_W = 32;
    localparam int EXP_W  = 32;
    localparam int SUM_W  = 2 * ELEM_W + 1;
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int LANES  = 4;

    localparam logic [ELEM_W-1:0] MODULUS_RESET = ELEM_W'(1000000007);

    // register indexes
    localparam logic REG_MODULUS = 1'b0;

    typedef struct packed {
        logic [ELEM_W-1:0] entry_00;
        logic [ELEM_W-1:0] entry_01;
        logic [ELEM_W-1:0] entry_10;
        logic [ELEM_W-1:0] entry_11;
        logic [EXP_W-1:0]  exponent;
    } in_item_t;

    typedef struct packed {
        logic [ELEM_W-1:0] power_00;
        logic [ELEM_W-1:0] power_01;
        logic [ELEM_W-1:0] power_10;
        logic [ELEM_W-1:0] power_11;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic pass;
    } lane_ctrl_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL2,
        L_SUM,
        L_RED
    } lane_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_ACC,
        S_SQRGO,
        S_SQR
    } seq_state_t;

endpackage

### hdl/m2mp_lane.sv
// one lane: (a*b + c*d) mod modulus, or a mod modulus in pass mode
// depends on m2mp_pkg
module m2mp_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  m2mp_pkg::lane_ctrl_t       ctrl,
    input  logic [m2mp_pkg::ELEM_W-1:0] a,
    input  logic [m2mp_pkg::ELEM_W-1:0] b,
    input  logic [m2mp_pkg::ELEM_W-1:0] c,
    input  logic [m2mp_pkg::ELEM_W-1:0] d,
    input  logic [m2mp_pkg::ELEM_W-1:0] modulus,
    output logic                       done,
    output logic [m2mp_pkg::ELEM_W-1:0] result
);
    import m2mp_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(SUM_W - 1);

    lane_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [2*ELEM_W-1:0]  prod_a_reg, prod_b_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [ELEM_W-1:0]    rem_reg, rem_next, result_reg;
    logic                 done_reg;
    logic [ELEM_W:0]      trial, diff;
    logic                 load_pass, load_mul1, load_mul2, load_sum, red_step, finish;

    // one restoring step per cycle, product bits msb first
    assign trial    = {rem_reg, sum_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, modulus};
    assign rem_next = (trial >= {1'b0, modulus}) ? diff[ELEM_W-1:0] : trial[ELEM_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE: if (ctrl.start) state_next = ctrl.pass ? L_RED : L_MUL2;
            L_MUL2: state_next = L_SUM;
            L_SUM:  state_next = L_RED;
            L_RED:  if (finish) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        load_pass = (state_reg == L_IDLE) && ctrl.start && ctrl.pass;
        load_mul1 = (state_reg == L_IDLE) && ctrl.start && !ctrl.pass;
        load_mul2 = (state_reg == L_MUL2);
        load_sum  = (state_reg == L_SUM);
        red_step  = (state_reg == L_RED);
        finish    = red_step && ((modulus == '0) || (cnt_reg == LAST));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_mul1)
            prod_a_reg <= a * b;
        if (load_mul2)
            prod_b_reg <= c * d;
        if (load_pass || load_sum)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
        end
        if (load_pass)
            sum_reg <= SUM_W'(a);
        else if (load_sum)
            sum_reg <= SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);
        else if (red_step)
        begin
            sum_reg <= sum_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
        end
        // zero modulus means wrap at the element width
        if (finish)
            result_reg <= (modulus == '0) ? sum_reg[ELEM_W-1:0] : rem_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/matrix2x2_modular_power.sv
// top level of the 2x2 modular matrix power block: apb register, sequencer, lane merge
// depends on m2mp_pkg and m2mp_lane
//
// Each item carries a 2x2 matrix and an exponent and yields one item holding the
// matrix raised to that power, every entry taken modulo the modulus register
// (byte address 0, reset 1000000007; zero means wrap at 32 bits). Four lanes, one
// per matrix entry, each form a sum of two 32x32 products and reduce it with a
// one-bit-per-cycle restoring remainder over the 65-bit sum. The entries are first
// reduced in the lanes, then square-and-multiply runs over the exponent bits lsb
// first up to its highest set bit, one or two matrix products per bit. Exponent
// zero returns the identity 1,0,0,1. One item is worked on at a time; a finished
// item waits in the output register so the next one can be taken in.
module matrix2x2_modular_power #(
    parameter int EXP_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  m2mp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output m2mp_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import m2mp_pkg::*;

    // exponent bits beyond EXP_BITS are ignored
    localparam int EXP_USED = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - EXP_USED);

    seq_state_t         state_reg, state_next;
    logic [ELEM_W-1:0]  modulus_reg;
    logic [ELEM_W-1:0]  acc_reg  [LANES];
    logic [ELEM_W-1:0]  base_reg [LANES];
    logic [EXP_W-1:0]   exp_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               in_fire, out_fire, cfg_write, emit;
    logic               sel_acc;
    lane_ctrl_t         lane_ctrl;
    logic [LANES-1:0]   lane_done;
    logic [ELEM_W-1:0]  lane_result [LANES];
    logic [ELEM_W-1:0]  op_a [LANES];
    logic [ELEM_W-1:0]  op_b [LANES];
    logic [ELEM_W-1:0]  op_c [LANES];
    logic [ELEM_W-1:0]  op_d [LANES];
    logic [ELEM_W-1:0]  in_entry [LANES];
    logic               all_done;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MODULUS) ? modulus_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MODULUS_RESET;
        else if (cfg_write && (paddr[2] == REG_MODULUS))
            modulus_reg <= pwdata;
    end

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign all_done  = lane_done[0];

    // result leaves the loop once the exponent runs out and the output slot is free
    assign emit = (state_reg == S_CHECK) && (exp_reg == '0) && (!out_valid_reg || out_ready);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_REDUCE;
            S_REDUCE: if (all_done) state_next = S_CHECK;
            S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    if (emit) state_next = S_IDLE;
                end
                else if (exp_reg[0])
                    state_next = S_ACC;
                else
                    state_next = S_SQR;
            end
            S_ACC:    if (all_done) state_next = S_SQRGO;
            S_SQRGO:  state_next = S_SQR;
            S_SQR:    if (all_done) state_next = S_CHECK;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: lane start and operand selection
    always_comb
    begin
        lane_ctrl.start = 1'b0;
        lane_ctrl.pass  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                lane_ctrl.start = in_fire;
                lane_ctrl.pass  = 1'b1;
            end
            S_CHECK:  lane_ctrl.start = (exp_reg != '0);
            S_SQRGO:  lane_ctrl.start = 1'b1;
            default:  lane_ctrl.start = 1'b0;
        endcase
        sel_acc = (state_reg == S_ACC) || ((state_reg == S_CHECK) && exp_reg[0]);
    end

    assign in_entry[0] = in_data.entry_00;
    assign in_entry[1] = in_data.entry_01;
    assign in_entry[2] = in_data.entry_10;
    assign in_entry[3] = in_data.entry_11;

    // lane k computes entry (row k/2, col k%2) of left * base
    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            localparam int ROW = k / 2;
            localparam int COL = k % 2;

            always_comb
            begin
                if (state_reg == S_IDLE)
                    op_a[k] = in_entry[k];
                else
                    op_a[k] = sel_acc ? acc_reg[2*ROW] : base_reg[2*ROW];
                op_c[k] = sel_acc ? acc_reg[2*ROW+1] : base_reg[2*ROW+1];
                op_b[k] = base_reg[COL];
                op_d[k] = base_reg[2+COL];
            end

            m2mp_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (lane_ctrl),
                .a       (op_a[k]),
                .b       (op_b[k]),
                .c       (op_c[k]),
                .d       (op_d[k]),
                .modulus (modulus_reg),
                .done    (lane_done[k]),
                .result  (lane_result[k])
            );
        end
    endgenerate

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // merge: lane results land in acc or base
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            exp_reg    <= in_data.exponent & EXP_MASK;
            acc_reg[0] <= ELEM_W'(1);
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            acc_reg[3] <= ELEM_W'(1);
        end
        if (all_done && ((state_reg == S_REDUCE) || (state_reg == S_SQR)))
            base_reg <= lane_result;
        if (all_done && (state_reg == S_ACC))
            acc_reg <= lane_result;
        if (all_done && (state_reg == S_SQR))
            exp_reg <= exp_reg >> 1;
        if (emit)
        begin
            out_reg.power_00 <= acc_reg[0];
            out_reg.power_01 <= acc_reg[1];
            out_reg.power_10 <= acc_reg[2];
            out_reg.power_11 <= acc_reg[3];
        end
    end

    // lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done == '0) || (lane_done == '1))
        else $error("lanes out of step");

    // lane results only arrive while the sequencer waits for them
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> ((state_reg == S_REDUCE) || (state_reg == S_ACC)
                          || (state_reg == S_SQR)))
        else $error("unexpected lane result");

    // a new result only comes out after the exponent is used up
    a_emit_on_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == S_CHECK) && (exp_reg == '0)))
        else $error("result emitted early");

    // an accepted item starts the entry reduction
    a_accept_reduces: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_REDUCE))
        else $error("accepted item not started");

endmodule
